// ----- design/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on clk, off during rst
`define VDFI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication form
`define VDFI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication form
`define VDFI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/vdfi_pkg.sv -----
`default_nettype none

package vdfi_pkg;

  localparam int POINT_DEPTH    = 256;
  localparam int FAN_DEPTH      = 256;
  localparam int MAX_FAN_POINTS = 8;

  localparam int FAN_POINT_LIMIT = (MAX_FAN_POINTS > 8) ? 8 : MAX_FAN_POINTS;

  localparam int PT_IDX_W  = $clog2(POINT_DEPTH);
  localparam int PT_CNT_W  = PT_IDX_W + 1;
  localparam int FAN_CNT_W = $clog2(FAN_DEPTH) + 1;
  localparam int KEY_W     = 24;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_RES
  } st_t;

  typedef struct packed {
    logic       done;
    logic [7:0] number;
    logic [2:0] tertiary;
    logic [7:0] material;
    logic       full;
    logic [2:0] position;
  } fan_rec_t;

endpackage

`default_nettype wire

// ----- design/vertex_dedup_fan_indexer.sv -----
// Path: input registered, compare across the cell row registered, then the resolve/append
//   step loads the output register. A new vertex is taken as the last one resolves, not
//   during the compare; resolve stalls while the output is held (m_tvalid && !m_tready).
// Reset (rst, synchronous): all table cells invalid, point, fan and position
//   counters cleared, output register empty. No clearing pass.
`default_nettype none

module vertex_dedup_fan_indexer (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // vertex_x, vertex_y, vertex_z, material
  input  wire logic        s_tlast,   // fan_end
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // point_index, was_new, table_full, fan_position,
                                      // fan_number, tertiary_count, fan_material,
                                      // fans_full, zero pad
  output logic             m_tlast    // fan_done
);

  vdfi_pkg::st_t state, state_next;

  logic [vdfi_pkg::KEY_W-1:0]       key;
  logic                             fan_end;
  logic [7:0]                       material;
  logic [vdfi_pkg::PT_CNT_W-1:0]    point_count;

  logic                             accept;
  logic                             finish;
  logic                             cmp_en;
  logic                             append;
  logic                             hit;
  logic                             tfull;
  logic [vdfi_pkg::PT_IDX_W-1:0]    hit_idx;
  logic [vdfi_pkg::PT_IDX_W-1:0]    idx;
  logic [vdfi_pkg::POINT_DEPTH-1:0] valid;
  logic [vdfi_pkg::POINT_DEPTH-1:0] match;
  vdfi_pkg::fan_rec_t               rec;

  always_comb begin
    state_next = state;
    unique case (state)
      vdfi_pkg::ST_IDLE: if (accept) state_next = vdfi_pkg::ST_CMP;
      vdfi_pkg::ST_CMP:  state_next = vdfi_pkg::ST_RES;
      vdfi_pkg::ST_RES: begin
        if (finish) state_next = accept ? vdfi_pkg::ST_CMP : vdfi_pkg::ST_IDLE;
      end
      default: state_next = vdfi_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    finish   = (state == vdfi_pkg::ST_RES) && (!m_tvalid || m_tready);
    s_tready = (state == vdfi_pkg::ST_IDLE) || finish;
    cmp_en   = (state == vdfi_pkg::ST_CMP);
  end

  assign accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vdfi_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key      <= s_tdata[23:0];
      material <= s_tdata[31:24];
      fan_end  <= s_tlast;
    end
  end

  genvar g;
  generate
    for (g = 0; g < vdfi_pkg::POINT_DEPTH; g++) begin : g_cell
      vdfi_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .key        (key),
        .cmp_en     (cmp_en),
        .append     (append),
        .prev_valid ((g == 0) ? 1'b1 : valid[(g == 0) ? 0 : g - 1]),
        .valid      (valid[g]),
        .match      (match[g])
      );
    end
  endgenerate

  // entries are unique, so at most one match bit is set
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < vdfi_pkg::POINT_DEPTH; i++) begin
      if (match[i]) hit_idx = hit_idx | vdfi_pkg::PT_IDX_W'(i);
    end
  end

  assign hit    = |match;
  assign tfull  = !hit && (point_count == vdfi_pkg::PT_CNT_W'(vdfi_pkg::POINT_DEPTH));
  assign append = finish && !hit;
  assign idx    = hit ? hit_idx : (tfull ? '0 : point_count[vdfi_pkg::PT_IDX_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= '0;
    end else if (append && !tfull) begin
      point_count <= point_count + 1'b1;
    end
  end

  vdfi_fan_ctl u_fan (
    .clk      (clk),
    .rst      (rst),
    .step     (finish),
    .fan_end  (fan_end),
    .material (material),
    .rec      (rec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      m_tdata <= {7'd0, rec.full, rec.material, rec.tertiary, rec.number,
                  rec.position, tfull, !hit && !tfull, idx};
      m_tlast <= rec.done;
    end
  end

`include "assert_macros.svh"

  `VDFI_ASSERT(a_match_unique, $onehot0(match), "more than one table entry matched")
  `VDFI_ASSERT(a_count_bound, point_count <= vdfi_pkg::PT_CNT_W'(vdfi_pkg::POINT_DEPTH),
               "point count past depth")
  `VDFI_ASSERT_IMP(a_no_accept_in_cmp, state == vdfi_pkg::ST_CMP, !s_tready,
                   "input taken during compare")
  `VDFI_ASSERT_NXT(a_append_counts, append && !tfull,
                   point_count == $past(point_count) + 1'b1, "append did not advance count")

endmodule

`default_nettype wire

// ----- design/vdfi_cell.sv -----
`default_nettype none

module vdfi_cell (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic [vdfi_pkg::KEY_W-1:0] key,
  input  wire logic                      cmp_en,
  input  wire logic                      append,
  input  wire logic                      prev_valid,
  output logic                           valid,
  output logic                           match
);

  logic [vdfi_pkg::KEY_W-1:0] entry;

  // first empty cell in the row takes the appended vertex
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (append && prev_valid && !valid) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (append && prev_valid && !valid) begin
      entry <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      match <= 1'b0;
    end else if (cmp_en) begin
      match <= valid && (entry == key);
    end
  end

endmodule

`default_nettype wire

// ----- design/vdfi_fan_ctl.sv -----
`default_nettype none

module vdfi_fan_ctl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire logic             fan_end,
  input  wire logic [7:0]       material,
  output vdfi_pkg::fan_rec_t    rec
);

  logic [2:0]                     position;
  logic [vdfi_pkg::FAN_CNT_W-1:0] fan_count;
  logic                           fans_full;

  assign fans_full = (fan_count == vdfi_pkg::FAN_CNT_W'(vdfi_pkg::FAN_DEPTH));

  always_comb begin
    rec          = '0;
    rec.position = position;
    if (fan_end) begin
      rec.done     = 1'b1;
      rec.tertiary = (position != 3'd0) ? position - 3'd1 : 3'd0;
      rec.material = material;
      rec.full     = fans_full;
      rec.number   = fans_full ? 8'd0 : fan_count[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position  <= '0;
      fan_count <= '0;
    end else if (step) begin
      if (fan_end) begin
        position <= '0;
        if (!fans_full) begin
          fan_count <= fan_count + 1'b1;
        end
      end else if (position < 3'(vdfi_pkg::FAN_POINT_LIMIT - 1)) begin
        position <= position + 3'd1;
      end
    end
  end

endmodule

`default_nettype wire
